FILE: src/orsr_pkg.sv
// Shared types and constants for the ROM search decision core.
// Used by orsr_byte_mem, orsr_core, orsr_out_skid and onewire_rom_search.
package orsr_pkg;

  // Id geometry
  localparam int ID_BITS  = 64;
  localparam int NBYTES   = (ID_BITS + 7) / 8;
  localparam int IDX_W    = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int MEM_DEPTH = 1 << IDX_W;
  localparam int POS_W    = 7;
  localparam int ROM_W    = 64;

  localparam logic [POS_W-1:0] LAST_FORK_INIT = POS_W'(65);
  localparam logic [POS_W-1:0] ID_LAST        = POS_W'(ID_BITS);
  localparam logic [ROM_W-1:0] ID_MASK =
    (ID_BITS >= ROM_W) ? {ROM_W{1'b1}} : ((ROM_W'(1) << ID_BITS) - ROM_W'(1));

  // Operation codes on the input stream
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_START = 2'd1,
    OP_PAIR  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CLEARED     = 3'd0,
    ST_STARTED     = 3'd1,
    ST_ALL_FOUND   = 3'd2,
    ST_NO_PRESENCE = 3'd3,
    ST_BIT         = 3'd4,
    ST_DONE        = 3'd5,
    ST_CONFLICT    = 3'd6,
    ST_IGNORED     = 3'd7
  } status_e;

  // One result transaction
  typedef struct packed {
    status_e          status;
    logic             write_bit;
    logic [POS_W-1:0] bit_index;
    logic [ROM_W-1:0] rom_id;
  } res_t;

  // Address byte memory request from the core
  typedef struct packed {
    logic             clear;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: src/orsr_byte_mem.sv
// Byte-wide memory holding the stored search address, one entry per id byte.
// Depends on orsr_pkg; entries carry valid bits so a clear needs no pass over the entries.
module orsr_byte_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  orsr_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);
  import orsr_pkg::*;

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid_q, valid_d;
  logic [7:0]           rd_q;
  logic                 rd_valid_q;
  logic                 fwd;

  // Next valid bits: clear drops all, a write marks its entry
  always_comb begin
    valid_d = valid_q;
    if (req_i.clear) begin
      valid_d = '0;
    end else if (req_i.we) begin
      valid_d[req_i.waddr] = 1'b1;
    end
  end

  assign fwd = req_i.we && (req_i.waddr == req_i.raddr) && !req_i.clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rd_valid_q <= valid_d[req_i.raddr];
    end
  end

  // Write port and registered read port, forwarding a same-entry write
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (fwd) begin
      rd_q <= req_i.wdata;
    end else begin
      rd_q <= mem[req_i.raddr];
    end
  end

  // Unwritten entries read as zero
  assign rdata_o = rd_valid_q ? rd_q : 8'h00;

endmodule

FILE: src/orsr_core.sv
// Per-transaction decision logic of the ROM search walk.
// Depends on orsr_pkg; reads and writes address bytes through orsr_byte_mem.
module orsr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  orsr_pkg::op_e      op_i,
  input  logic               presence_i,
  input  logic               first_read_i,
  input  logic               second_read_i,
  input  logic [7:0]         mem_rdata_i,
  output orsr_pkg::mem_req_t mem_req_o,
  output orsr_pkg::res_t     res_o
);
  import orsr_pkg::*;

  logic [POS_W-1:0] position_q, position_d;
  logic [POS_W-1:0] last_fork_q, last_fork_d;
  logic [POS_W-1:0] pending_q, pending_d;
  logic [7:0]       byte_asm_q, byte_asm_d;
  logic             active_q, active_d;
  logic [ROM_W-1:0] rom_q, rom_d;

  logic [POS_W-1:0] p;
  logic [IDX_W-1:0] byte_sel;
  logic             prev_bit;
  logic             dir_bit;
  logic             bad;
  logic [7:0]       acc;
  logic [3:0]       kk;
  logic [7:0]       low_mask;
  logic [7:0]       new_byte;
  logic             commit;
  logic             done;

  // Bit position and stored bit under it
  assign p        = position_q + POS_W'(1);
  assign byte_sel = position_q[3 +: IDX_W];
  assign prev_bit = mem_rdata_i[position_q[2:0]];
  assign commit   = (p[2:0] == 3'd0) || (p >= ID_LAST);
  assign done     = (p >= ID_LAST);

  // Direction choice for one bit pair
  always_comb begin
    dir_bit   = 1'b0;
    bad       = 1'b0;
    pending_d = pending_q;
    if (!first_read_i) begin
      if (!second_read_i) begin
        if (p < last_fork_q) begin
          if (prev_bit) begin
            dir_bit = 1'b1;
          end else begin
            pending_d = p;
          end
        end else if (p == last_fork_q) begin
          dir_bit = 1'b1;
        end else begin
          pending_d = p;
        end
      end
    end else if (!second_read_i) begin
      dir_bit = 1'b1;
    end else begin
      bad = 1'b1;
    end
  end

  // Merge the assembled bits into the low end of the current byte
  assign acc      = byte_asm_q | {dir_bit, 7'd0};
  assign kk       = {1'b0, position_q[2:0]} + 4'd1;
  assign low_mask = 8'((9'd1 << kk) - 9'd1);
  assign new_byte = (mem_rdata_i & ~low_mask) | (8'(acc >> (4'd8 - kk)) & low_mask);

  // Operation sequencing
  always_comb begin
    position_d      = position_q;
    last_fork_d     = last_fork_q;
    byte_asm_d      = byte_asm_q;
    active_d        = active_q;
    rom_d           = rom_q;
    mem_req_o       = '0;
    res_o           = '0;
    res_o.status    = ST_IGNORED;
    if (in_valid_i) begin
      case (op_i)
        OP_CLEAR: begin
          position_d      = '0;
          last_fork_d     = LAST_FORK_INIT;
          byte_asm_d      = '0;
          active_d        = 1'b0;
          mem_req_o.clear = 1'b1;
          res_o.status    = ST_CLEARED;
        end
        OP_START: begin
          active_d = 1'b0;
          if (last_fork_q == '0) begin
            res_o.status = ST_ALL_FOUND;
          end else if (!presence_i) begin
            res_o.status = ST_NO_PRESENCE;
          end else begin
            active_d     = 1'b1;
            position_d   = '0;
            byte_asm_d   = '0;
            res_o.status = ST_STARTED;
          end
        end
        OP_PAIR: begin
          if (active_q) begin
            if (bad) begin
              active_d     = 1'b0;
              res_o.status = ST_CONFLICT;
            end else begin
              res_o.write_bit = dir_bit;
              res_o.bit_index = p;
              position_d      = p;
              if (commit) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = byte_sel;
                mem_req_o.wdata = new_byte;
                rom_d[{byte_sel, 3'b000} +: 8] = new_byte;
                byte_asm_d      = '0;
              end else begin
                byte_asm_d = acc >> 1;
              end
              if (done) begin
                last_fork_d  = pending_d;
                active_d     = 1'b0;
                res_o.rom_id = rom_d & ID_MASK;
                res_o.status = ST_DONE;
              end else begin
                res_o.status = ST_BIT;
              end
            end
          end
        end
        default: begin
          res_o.status = ST_IGNORED;
        end
      endcase
    end
    mem_req_o.raddr = position_d[3 +: IDX_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      last_fork_q <= LAST_FORK_INIT;
      pending_q   <= '0;
      byte_asm_q  <= '0;
      active_q    <= 1'b0;
    end else begin
      position_q  <= position_d;
      last_fork_q <= last_fork_d;
      byte_asm_q  <= byte_asm_d;
      active_q    <= active_d;
      if (in_valid_i && op_i == OP_START) begin
        pending_q <= '0;
      end else if (in_valid_i && op_i == OP_CLEAR) begin
        pending_q <= '0;
      end else if (in_valid_i && op_i == OP_PAIR && active_q && !bad) begin
        pending_q <= pending_d;
      end
    end
  end

  // Assembled id bytes of the running pass
  always_ff @(posedge clk_i) begin
    rom_q <= rom_d;
  end

  // A decided bit advances the position by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && res_o.status == ST_BIT |=> position_q == $past(position_q) + POS_W'(1))
    else $error("position did not advance after a decided bit");

  // A finished or aborted pass leaves no pass running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (res_o.status == ST_DONE || res_o.status == ST_CONFLICT) |=> !active_q)
    else $error("pass still active after it ended");

  // Clearing restores the initial fork
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && op_i == OP_CLEAR |=> last_fork_q == LAST_FORK_INIT && !active_q)
    else $error("clear did not restore the walk");

  // The id is only reported at its last bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && res_o.status == ST_DONE |=> position_q == ID_LAST)
    else $error("id reported before its last bit");

endmodule

FILE: src/orsr_out_skid.sv
// Two-entry result buffer between the decision core and the output stream.
// Depends on orsr_pkg for the result type.
module orsr_out_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  orsr_pkg::res_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_ready_i,
  output orsr_pkg::res_t data_o
);
  import orsr_pkg::*;

  res_t       head_q, tail_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = head_q;
  assign pop     = valid_o && pop_ready_i;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Move payload between the two entries
  always_ff @(posedge clk_i) begin
    if (push_i && pop) begin
      if (cnt_q == 2'd1) begin
        head_q <= data_i;
      end else begin
        head_q <= tail_q;
        tail_q <= data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        tail_q <= data_i;
      end
    end else if (pop) begin
      head_q <= tail_q;
    end
  end

  // A full buffer keeps both entries until one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2)
    else $error("full buffer lost an entry");

endmodule

FILE: src/onewire_rom_search.sv
// Top level of the ROM search decision core: stream ports, core, byte memory
// and result buffer. Depends on orsr_pkg, orsr_byte_mem, orsr_core, orsr_out_skid.
//
//  Channel   Dir  tdata (low bit first)                        tuser
//  s_axis    in   presence, first_read, second_read (8 bits)   operation (2)
//  m_axis    out  write_bit, bit_index, rom_id (72 bits)       status (3)
//
// One transaction is accepted every cycle while the buffer has room; its result
// enters the buffer at the accepting edge and is offered on m_axis after older
// results. The stored address sits in a byte memory with a registered read at the
// byte of the next bit position, so bit pairs can arrive back to back.
// Reset clears the walk and all memory valid bits at once; no clearing pass.
// With the output stalled the two-entry buffer absorbs two results, then
// s_axis_tready drops until a result is taken.
module onewire_rom_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // presence, first_read, second_read
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // write_bit, bit_index[6:0], rom_id[63:0]
  output logic [2:0]  m_axis_tuser    // status
);
  import orsr_pkg::*;

  logic     accept;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;
  res_t     core_res;
  res_t     out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  orsr_byte_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  orsr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (accept),
    .op_i          (op_e'(s_axis_tuser)),
    .presence_i    (s_axis_tdata[0]),
    .first_read_i  (s_axis_tdata[1]),
    .second_read_i (s_axis_tdata[2]),
    .mem_rdata_i   (mem_rdata),
    .mem_req_o     (mem_req),
    .res_o         (core_res)
  );

  orsr_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (core_res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  // Pack the result transaction
  assign m_axis_tdata = {out_res.rom_id, out_res.bit_index, out_res.write_bit};
  assign m_axis_tuser = out_res.status;

endmodule
